// ===== rtl/evad_pkg.sv =====
// Shared types, constants and tables for the energy voice activity detector.
package evad_pkg;

  localparam int DEF_MAX_FRAME_SAMPLES = 1024;
  localparam int DEF_SAMPLE_BITS       = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] RST_ADAPT_FAST  = 16'd1311;
  localparam logic [15:0] RST_ADAPT_SLOW  = 16'd131;
  localparam logic [15:0] RST_SMOOTHING   = 16'd29491;
  localparam logic [11:0] RST_LOG_SLOPE   = 12'd230;
  localparam logic [15:0] RST_LOG_OFFSET  = 16'hFE80;  // -384
  localparam logic [15:0] RST_LEVEL_FLOOR = 16'hB000;  // -20480
  localparam logic [15:0] RST_LEVEL_CEIL  = 16'hE200;  // -7680

  localparam logic [31:0] FLOOR_RESET = 32'd107374;    // 1e-4 in Q0.30
  localparam logic [31:0] FLOOR_MIN   = 32'd107;       // 1e-7 in Q0.30
  localparam logic signed [18:0] DB_PER_LOG2 = 19'sd197283;
  localparam logic signed [16:0] SNR_MIN     = -17'sd15360;
  localparam logic signed [16:0] LEVEL_MIN   = -17'sd30720;
  localparam logic [21:0] LOG2_2P30 = 22'd1966080;     // 30.0 in Q.16
  localparam logic [30:0] SIG_LIMIT = 31'd720896;      // 22 half steps in Q.16

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADAPT_FAST  = 3'd0,
    CFG_ADAPT_SLOW  = 3'd1,
    CFG_SMOOTHING   = 3'd2,
    CFG_LOG_SLOPE   = 3'd3,
    CFG_LOG_OFFSET  = 3'd4,
    CFG_LEVEL_FLOOR = 3'd5,
    CFG_LEVEL_CEIL  = 3'd6
  } cfg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQUARE, ST_ACCUM,
    ST_EDIV_GO, ST_EDIV_WAIT, ST_EDIV_END,
    ST_NF_MUL0, ST_NF_MUL1, ST_NF_SUM,
    ST_LOGE_GO, ST_LOGE_WAIT, ST_LOGE_END,
    ST_LOGF_GO, ST_LOGF_WAIT, ST_LOGF_END,
    ST_SNR_MUL, ST_SNR_CLAMP, ST_LVL_MUL, ST_LVL_CLAMP,
    ST_Z_MUL, ST_SIGMOID,
    ST_LP_GO, ST_LP_WAIT, ST_LP_END,
    ST_SM_MUL0, ST_SM_MUL1, ST_SM_SUM
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SQUARE, OP_ACCUM,
    OP_EDIV_GO, OP_EDIV_END,
    OP_NF_MUL0, OP_NF_MUL1, OP_NF_SUM,
    OP_LOGE_GO, OP_LOGE_END, OP_LOGF_GO, OP_LOGF_END,
    OP_SNR_MUL, OP_SNR_CLAMP, OP_LVL_MUL, OP_LVL_CLAMP,
    OP_Z_MUL, OP_SIGMOID,
    OP_LP_GO, OP_LP_END,
    OP_SM_MUL0, OP_SM_MUL1, OP_SM_SUM
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
    logic log_done;
    logic lp_direct;
    logic out_free;
  } status_t;

  // logistic sigma at half steps, Q0.16
  function automatic logic [16:0] sig_tab(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:  v = 17'd32768;
      5'd1:  v = 17'd40793;
      5'd2:  v = 17'd47911;
      5'd3:  v = 17'd53581;
      5'd4:  v = 17'd57724;
      5'd5:  v = 17'd60565;
      5'd6:  v = 17'd62428;
      5'd7:  v = 17'd63615;
      5'd8:  v = 17'd64357;
      5'd9:  v = 17'd64816;
      5'd10: v = 17'd65097;
      5'd11: v = 17'd65269;
      5'd12: v = 17'd65374;
      5'd13: v = 17'd65438;
      5'd14: v = 17'd65476;
      5'd15: v = 17'd65500;
      5'd16: v = 17'd65514;
      5'd17: v = 17'd65523;
      5'd18: v = 17'd65528;
      5'd19: v = 17'd65531;
      5'd20: v = 17'd65533;
      5'd21: v = 17'd65534;
      default: v = 17'd65535;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/evad_div.sv =====
// Restoring divider, one quotient bit per cycle.
module evad_div #(
  parameter int N = 41,
  parameter int D = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [N-1:0] dividend_i,
  input  logic [D-1:0] divisor_i,
  output logic         done_o,
  output logic [N-1:0] quot_o
);
  localparam int CW = $clog2(N);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [D-1:0]  rem_q, rem_d, dv_q, dv_d;
  logic [N-1:0]  quo_q, quo_d;
  logic [D:0]    r2, diff;
  logic          ge;

  always_comb begin
    r2     = {rem_q, quo_q[N-1]};
    diff   = r2 - {1'b0, dv_q};
    ge     = r2 >= {1'b0, dv_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(N - 1);
      rem_d  = '0;
      dv_d   = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[D-1:0] : r2[D-1:0];
      quo_d = {quo_q[N-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dv_q  <= dv_d;
    quo_q <= quo_d;
  end

  assign done_o = !busy_q;
  assign quot_o = quo_q;
endmodule

// ===== rtl/evad_log2.sv =====
// Bit-serial log2 in Q.16: normalize one bit a cycle, then 16 squaring steps.
module evad_log2 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] x_i,
  output logic        done_o,
  output logic [20:0] log_o
);
  logic        busy_q, busy_d, norm_q, norm_d;
  logic [4:0]  n_q, n_d;
  logic [3:0]  it_q, it_d;
  logic [31:0] m_q, m_d;
  logic [15:0] frac_q, frac_d;
  logic [63:0] sq;
  logic [32:0] t;

  always_comb begin
    sq     = 64'(m_q) * 64'(m_q);
    t      = sq[63:31];
    busy_d = busy_q;
    norm_d = norm_q;
    n_d    = n_q;
    it_d   = it_q;
    m_d    = m_q;
    frac_d = frac_q;
    if (start_i) begin
      busy_d = 1'b1;
      norm_d = 1'b1;
      n_d    = 5'd31;
      it_d   = '0;
      m_d    = x_i;
      frac_d = '0;
    end else if (busy_q) begin
      if (norm_q) begin
        if (m_q[31]) begin
          norm_d = 1'b0;
        end else begin
          m_d = {m_q[30:0], 1'b0};
          n_d = n_q - 1'b1;
        end
      end else begin
        m_d    = t[32] ? t[32:1] : t[31:0];
        frac_d = {frac_q[14:0], t[32]};
        it_d   = it_q + 1'b1;
        if (it_q == 4'd15) begin
          busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      norm_q <= 1'b0;
      it_q   <= '0;
    end else begin
      busy_q <= busy_d;
      norm_q <= norm_d;
      it_q   <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    m_q    <= m_d;
    frac_q <= frac_d;
  end

  assign done_o = !busy_q;
  assign log_o  = {n_q, frac_q};
endmodule

// ===== rtl/evad_dp.sv =====
// Datapath: accumulator, config registers, floor update, dB, logistic, level ramp, smoothing.
module evad_dp #(
  parameter int MAX_FRAME_SAMPLES = evad_pkg::DEF_MAX_FRAME_SAMPLES,
  parameter int SAMPLE_BITS       = evad_pkg::DEF_SAMPLE_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  evad_pkg::cmd_t                  cmd_i,
  output evad_pkg::status_t               status_o,
  input  logic signed [SAMPLE_BITS-1:0]   sample_i,
  input  logic                            last_sample_i,
  input  logic                            clear_state_i,
  input  logic                            cfg_we_i,
  input  logic [evad_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [evad_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [15:0]                     probability_o,
  output logic                            likely_noise_o,
  output logic                            frame_overrun_o
);
  import evad_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int SUM_W = SQ_W + CNT_W;
  localparam int DIV_N = (SUM_W > 32) ? SUM_W : 32;
  localparam int DIV_D = (CNT_W > 16) ? CNT_W : 16;
  localparam int SH_R  = (SQ_W >= 32) ? SQ_W - 32 : 0;
  localparam int SH_L  = (SQ_W >= 32) ? 0 : 32 - SQ_W;

  // config
  logic [15:0] adapt_fast_q, adapt_slow_q, smoothing_q;
  logic [11:0] slope_q;
  logic [15:0] offset_q, lfloor_q, lceil_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adapt_fast_q <= RST_ADAPT_FAST;
      adapt_slow_q <= RST_ADAPT_SLOW;
      smoothing_q  <= RST_SMOOTHING;
      slope_q      <= RST_LOG_SLOPE;
      offset_q     <= RST_LOG_OFFSET;
      lfloor_q     <= RST_LEVEL_FLOOR;
      lceil_q      <= RST_LEVEL_CEIL;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ADAPT_FAST:  adapt_fast_q <= cfg_data_i;
        CFG_ADAPT_SLOW:  adapt_slow_q <= cfg_data_i;
        CFG_SMOOTHING:   smoothing_q  <= cfg_data_i;
        CFG_LOG_SLOPE:   slope_q      <= cfg_data_i[11:0];
        CFG_LOG_OFFSET:  offset_q     <= cfg_data_i;
        CFG_LEVEL_FLOOR: lfloor_q     <= cfg_data_i;
        CFG_LEVEL_CEIL:  lceil_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // state
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic              last_q;
  logic [SQ_W-1:0]   sq_q, sq_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ovr_q, ovr_d;
  logic [31:0]       nf_q, nf_d;
  logic [15:0]       sp_q, sp_d;
  logic [31:0]       e_q, e_d;
  logic              noise_q, noise_d;
  logic [48:0]       mula_q, mula_d, mulb_q, mulb_d;
  logic [20:0]       le_q, le_d, lf_q, lf_d;
  logic signed [40:0] prod_q, prod_d;
  logic signed [16:0] snr_q, snr_d, lvl_q, lvl_d;
  logic signed [30:0] z_q, z_d;
  logic [16:0]       p_q, p_d;
  logic [15:0]       lp_q, lp_d;
  logic              ov_q, ov_d;
  logic [15:0]       oprob_q, oprob_d;
  logic              onoise_q, onoise_d, oovr_q, oovr_d;

  // shared units
  logic             div_start, div_done;
  logic [DIV_N-1:0] div_n, div_quo;
  logic [DIV_D-1:0] div_d;
  logic             log_start, log_done;
  logic [31:0]      log_x;
  logic [20:0]      log_r;

  evad_div #(.N(DIV_N), .D(DIV_D)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_n), .divisor_i(div_d),
    .done_o(div_done), .quot_o(div_quo)
  );

  evad_log2 u_log (
    .clk_i, .rst_ni,
    .start_i(log_start), .x_i(log_x), .done_o(log_done), .log_o(log_r)
  );

  // combinational helpers
  logic [63:0]        e_wide;
  logic               noise_c;
  logic [15:0]        rate;
  logic [49:0]        nf_sum;
  logic [33:0]        nf_sh;
  logic signed [21:0] ldiff;
  logic signed [40:0] db_sh;
  logic signed [17:0] zdiff, num, den;
  logic [30:0]        az;
  logic [4:0]         si;
  logic [14:0]        sf;
  logic [16:0]        s0, s1, sv;
  logic [27:0]        sstep;
  logic               inverted, direct;
  logic [15:0]        lp_dir;
  logic [16:0]        pm;
  logic [33:0]        sm_sum;
  logic [17:0]        sm_sh;

  always_comb begin
    e_wide  = (SQ_W >= 32) ? (64'(div_quo) >> SH_R) : (64'(div_quo) << SH_L);
    noise_c = ({1'b0, e_q, 1'b0} <= 34'(nf_q) * 34'd3);
    rate    = noise_c ? adapt_fast_q : adapt_slow_q;
    nf_sum  = 50'(mula_q) + 50'(mulb_q) + 50'd32768;
    nf_sh   = nf_sum[49:16];
    ldiff   = (cmd_i.op == OP_SNR_MUL) ? $signed({1'b0, le_q}) - $signed({1'b0, lf_q})
                                       : $signed({1'b0, le_q}) - $signed(LOG2_2P30);
    db_sh   = prod_q >>> 24;
    zdiff   = 18'(snr_q) - 18'($signed(offset_q));
    az      = z_q[30] ? -z_q : z_q;
    si      = az[19:15];
    sf      = az[14:0];
    s0      = sig_tab(si);
    s1      = sig_tab(si + 5'd1);
    sstep   = 28'(s1 - s0) * 28'(sf);
    sv      = (az >= SIG_LIMIT) ? 17'd65536 : s0 + 17'(sstep >> 15);
    num     = 18'(lvl_q) - 18'($signed(lfloor_q));
    den     = 18'($signed(lceil_q)) - 18'($signed(lfloor_q));
    inverted = $signed(lceil_q) <= $signed(lfloor_q);
    direct  = inverted || (num <= 0) || (num >= den);
    if (inverted) begin
      lp_dir = (lvl_q >= 17'($signed(lceil_q))) ? 16'hFFFF : 16'h0;
    end else begin
      lp_dir = (num <= 0) ? 16'h0 : 16'hFFFF;
    end
    pm      = ({1'b0, lp_q} > p_q) ? {1'b0, lp_q} : p_q;
    sm_sum  = 34'(mula_q) + 34'(mulb_q) + 34'd32768;
    sm_sh   = sm_sum[33:16];
  end

  always_comb begin
    div_start = 1'b0;
    div_n     = DIV_N'(sum_q);
    div_d     = DIV_D'(cnt_q);
    log_start = 1'b0;
    log_x     = (e_q == '0) ? 32'd1 : e_q;
    if (cmd_i.op == OP_EDIV_GO) begin
      div_start = 1'b1;
    end
    if (cmd_i.op == OP_LP_GO) begin
      div_start = !direct;
      div_n     = DIV_N'({num[15:0], 16'h0});
      div_d     = DIV_D'(den[15:0]);
    end
    if (cmd_i.op == OP_LOGE_GO) begin
      log_start = 1'b1;
    end
    if (cmd_i.op == OP_LOGF_GO) begin
      log_start = 1'b1;
      log_x     = nf_q;
    end
  end

  always_comb begin
    sq_d     = sq_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    ovr_d    = ovr_q;
    nf_d     = nf_q;
    sp_d     = sp_q;
    e_d      = e_q;
    noise_d  = noise_q;
    mula_d   = mula_q;
    mulb_d   = mulb_q;
    le_d     = le_q;
    lf_d     = lf_q;
    prod_d   = prod_q;
    snr_d    = snr_q;
    lvl_d    = lvl_q;
    z_d      = z_q;
    p_d      = p_q;
    lp_d     = lp_q;
    ov_d     = ov_q && !out_ready_i;
    oprob_d  = oprob_q;
    onoise_d = onoise_q;
    oovr_d   = oovr_q;
    case (cmd_i.op)
      OP_LOAD: begin
        if (clear_state_i) begin
          nf_d = FLOOR_RESET;
          sp_d = '0;
        end
      end
      OP_SQUARE: sq_d = SQ_W'(sample_q * sample_q);
      OP_ACCUM: begin
        if (cnt_q < CNT_W'(MAX_FRAME_SAMPLES)) begin
          sum_d = sum_q + SUM_W'(sq_q);
          cnt_d = cnt_q + 1'b1;
        end else begin
          ovr_d = 1'b1;
        end
      end
      OP_EDIV_END: e_d = e_wide[31:0];
      OP_NF_MUL0: begin
        noise_d = noise_c;
        mula_d  = 49'(17'h10000 - 17'(rate)) * 49'(nf_q);
      end
      OP_NF_MUL1: mulb_d = 49'(noise_q ? adapt_fast_q : adapt_slow_q) * 49'(e_q);
      OP_NF_SUM:  nf_d = (nf_sh < 34'(FLOOR_MIN)) ? FLOOR_MIN : nf_sh[31:0];
      OP_LOGE_END: le_d = log_r;
      OP_LOGF_END: lf_d = log_r;
      OP_SNR_MUL, OP_LVL_MUL: prod_d = 41'(ldiff) * 41'(DB_PER_LOG2);
      OP_SNR_CLAMP: begin
        if (e_q == '0 || $signed(db_sh[16:0]) < SNR_MIN) begin
          snr_d = SNR_MIN;
        end else begin
          snr_d = db_sh[16:0];
        end
      end
      OP_LVL_CLAMP: begin
        if (e_q == '0 || $signed(db_sh[16:0]) < LEVEL_MIN) begin
          lvl_d = LEVEL_MIN;
        end else begin
          lvl_d = db_sh[16:0];
        end
      end
      OP_Z_MUL: z_d = 31'(zdiff) * 31'($signed({1'b0, slope_q}));
      OP_SIGMOID: begin
        if (z_q[30]) begin
          p_d = 17'h10000 - sv;
        end else begin
          p_d = (sv > 17'd65535) ? 17'd65535 : sv;
        end
      end
      OP_LP_GO: lp_d = lp_dir;
      OP_LP_END: lp_d = div_quo[15:0];
      OP_SM_MUL0: mula_d = 49'(smoothing_q) * 49'(pm);
      OP_SM_MUL1: mulb_d = 49'(17'h10000 - 17'(smoothing_q)) * 49'(sp_q);
      OP_SM_SUM: begin
        sp_d     = (sm_sh > 18'd65535) ? 16'hFFFF : sm_sh[15:0];
        oprob_d  = (sm_sh > 18'd65535) ? 16'hFFFF : sm_sh[15:0];
        onoise_d = noise_q;
        oovr_d   = ovr_q;
        ov_d     = 1'b1;
        sum_d    = '0;
        cnt_d    = '0;
        ovr_d    = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      ovr_q  <= 1'b0;
      nf_q   <= FLOOR_RESET;
      sp_q   <= '0;
      ov_q   <= 1'b0;
      last_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      ovr_q <= ovr_d;
      nf_q  <= nf_d;
      sp_q  <= sp_d;
      ov_q  <= ov_d;
      if (cmd_i.op == OP_LOAD) begin
        last_q <= last_sample_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      sample_q <= sample_i;
    end
    sq_q     <= sq_d;
    e_q      <= e_d;
    noise_q  <= noise_d;
    mula_q   <= mula_d;
    mulb_q   <= mulb_d;
    le_q     <= le_d;
    lf_q     <= lf_d;
    prod_q   <= prod_d;
    snr_q    <= snr_d;
    lvl_q    <= lvl_d;
    z_q      <= z_d;
    p_q      <= p_d;
    lp_q     <= lp_d;
    oprob_q  <= oprob_d;
    onoise_q <= onoise_d;
    oovr_q   <= oovr_d;
  end

  assign status_o.last      = last_q;
  assign status_o.div_done  = div_done;
  assign status_o.log_done  = log_done;
  assign status_o.lp_direct = direct;
  assign status_o.out_free  = !ov_q || out_ready_i;

  assign out_valid_o     = ov_q;
  assign probability_o   = oprob_q;
  assign likely_noise_o  = onoise_q;
  assign frame_overrun_o = oovr_q;
endmodule

// ===== rtl/evad_ctrl.sv =====
// Sequencer that walks the datapath through sample and frame-end steps.
module evad_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  evad_pkg::status_t status_i,
  output evad_pkg::cmd_t    cmd_o
);
  import evad_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:       if (in_valid_i) state_d = ST_SQUARE;
      ST_SQUARE:     state_d = ST_ACCUM;
      ST_ACCUM:      state_d = status_i.last ? ST_EDIV_GO : ST_IDLE;
      ST_EDIV_GO:    state_d = ST_EDIV_WAIT;
      ST_EDIV_WAIT:  if (status_i.div_done) state_d = ST_EDIV_END;
      ST_EDIV_END:   state_d = ST_NF_MUL0;
      ST_NF_MUL0:    state_d = ST_NF_MUL1;
      ST_NF_MUL1:    state_d = ST_NF_SUM;
      ST_NF_SUM:     state_d = ST_LOGE_GO;
      ST_LOGE_GO:    state_d = ST_LOGE_WAIT;
      ST_LOGE_WAIT:  if (status_i.log_done) state_d = ST_LOGE_END;
      ST_LOGE_END:   state_d = ST_LOGF_GO;
      ST_LOGF_GO:    state_d = ST_LOGF_WAIT;
      ST_LOGF_WAIT:  if (status_i.log_done) state_d = ST_LOGF_END;
      ST_LOGF_END:   state_d = ST_SNR_MUL;
      ST_SNR_MUL:    state_d = ST_SNR_CLAMP;
      ST_SNR_CLAMP:  state_d = ST_LVL_MUL;
      ST_LVL_MUL:    state_d = ST_LVL_CLAMP;
      ST_LVL_CLAMP:  state_d = ST_Z_MUL;
      ST_Z_MUL:      state_d = ST_SIGMOID;
      ST_SIGMOID:    state_d = ST_LP_GO;
      ST_LP_GO:      state_d = status_i.lp_direct ? ST_SM_MUL0 : ST_LP_WAIT;
      ST_LP_WAIT:    if (status_i.div_done) state_d = ST_LP_END;
      ST_LP_END:     state_d = ST_SM_MUL0;
      ST_SM_MUL0:    state_d = ST_SM_MUL1;
      ST_SM_MUL1:    state_d = ST_SM_SUM;
      ST_SM_SUM:     if (status_i.out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      ST_SQUARE:    cmd_o.op = OP_SQUARE;
      ST_ACCUM:     cmd_o.op = OP_ACCUM;
      ST_EDIV_GO:   cmd_o.op = OP_EDIV_GO;
      ST_EDIV_END:  cmd_o.op = OP_EDIV_END;
      ST_NF_MUL0:   cmd_o.op = OP_NF_MUL0;
      ST_NF_MUL1:   cmd_o.op = OP_NF_MUL1;
      ST_NF_SUM:    cmd_o.op = OP_NF_SUM;
      ST_LOGE_GO:   cmd_o.op = OP_LOGE_GO;
      ST_LOGE_END:  cmd_o.op = OP_LOGE_END;
      ST_LOGF_GO:   cmd_o.op = OP_LOGF_GO;
      ST_LOGF_END:  cmd_o.op = OP_LOGF_END;
      ST_SNR_MUL:   cmd_o.op = OP_SNR_MUL;
      ST_SNR_CLAMP: cmd_o.op = OP_SNR_CLAMP;
      ST_LVL_MUL:   cmd_o.op = OP_LVL_MUL;
      ST_LVL_CLAMP: cmd_o.op = OP_LVL_CLAMP;
      ST_Z_MUL:     cmd_o.op = OP_Z_MUL;
      ST_SIGMOID:   cmd_o.op = OP_SIGMOID;
      ST_LP_GO:     cmd_o.op = OP_LP_GO;
      ST_LP_END:    cmd_o.op = OP_LP_END;
      ST_SM_MUL0:   cmd_o.op = OP_SM_MUL0;
      ST_SM_MUL1:   cmd_o.op = OP_SM_MUL1;
      ST_SM_SUM:    if (status_i.out_free) cmd_o.op = OP_SM_SUM;
      default:      cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// ===== rtl/energy_voice_activity_detector_unit.sv =====
// Energy voice activity detector: sequencer plus datapath, one probability per frame.
// Each sample beat is accepted, squared and accumulated in turn; the next beat is taken after that.
// The frame-end beat adds a divide for the mean energy, two log2 runs (energy and floor),
// a second divide for the level ramp (skipped when the level is clamped) and single
// steps in between; its length is set by the bit-serial divider and log2 unit, plus any
// stall while the result register is full.
// Reset (async, active low) restores config defaults, empty frame and default floor.
module energy_voice_activity_detector_unit #(
  parameter int MAX_FRAME_SAMPLES = evad_pkg::DEF_MAX_FRAME_SAMPLES,
  parameter int SAMPLE_BITS       = evad_pkg::DEF_SAMPLE_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // sample channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]   sample_i,
  input  logic                            last_sample_i,
  input  logic                            clear_state_i,
  // result channel, held in an output register so a new frame can start
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [15:0]                     probability_o,
  output logic                            likely_noise_o,
  output logic                            frame_overrun_o,
  // config write port
  input  logic                            cfg_we_i,
  input  logic [evad_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [evad_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import evad_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: one state per datapath step, waits on divider/log2 done and a free result register
  evad_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .status_i(status), .cmd_o(cmd)
  );

  // datapath owns all arithmetic, state and the output beat register
  evad_dp #(
    .MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .status_o(status),
    .sample_i, .last_sample_i, .clear_state_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .out_valid_o, .out_ready_i,
    .probability_o, .likely_noise_o, .frame_overrun_o
  );
endmodule
